### src/mono_framebuffer_draw_engine_assert.svh
// assertion macros for the draw engine checker
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_ASSERT_SVH

// implication checked from the next cycle, off during reset
`define MFB_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("draw engine assertion failed");

// same-cycle implication, checked also while reset is held
`define MFB_ASSERT_NOW(lbl, clk, a, b) \
    lbl: assert property (@(posedge clk) (a) |-> (b)) \
        else $error("draw engine assertion failed");

`endif

### src/mfb_pkg.sv
`timescale 1ns / 1ps
package mfb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 256;
    localparam int SCREEN_HEIGHT_DEF = 128;

    localparam logic [2:0] ACT_CLEAR   = 3'd0;
    localparam logic [2:0] ACT_PIXEL   = 3'd1;
    localparam logic [2:0] ACT_FILL    = 3'd2;
    localparam logic [2:0] ACT_OUTLINE = 3'd3;
    localparam logic [2:0] ACT_HLINE   = 3'd4;
    localparam logic [2:0] ACT_VLINE   = 3'd5;
    localparam logic [2:0] ACT_GLYPH   = 3'd6;
    localparam logic [2:0] ACT_READ    = 3'd7;

    typedef logic signed [19:0] coord_t;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] x_start;
        logic signed [15:0] y_start;
        logic signed [15:0] x_end;
        logic signed [15:0] y_end;
        logic signed [15:0] length;
        logic               color;
        logic [63:0]        glyph_bits;
        logic [3:0]         scale;
        logic [11:0]        byte_index;
    } cmd_t;

    typedef struct packed {
        logic [7:0]         read_data;
        logic signed [15:0] next_x;
    } result_t;

endpackage

### src/mfb_ram.sv
`timescale 1ns / 1ps
module mfb_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/mfb_seq.sv
`timescale 1ns / 1ps
module mfb_seq #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF,
    localparam int ROW_BYTES    = (SCREEN_WIDTH + 7) / 8,
    localparam int STORE_BYTES  = ROW_BYTES * SCREEN_HEIGHT,
    localparam int AW           = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mfb_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output mfb_pkg::result_t res,
    input  logic             res_take,
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [7:0]       ram_wdata,
    output logic             ram_re,
    output logic [AW-1:0]    ram_raddr,
    input  logic [7:0]       ram_rdata
);

    import mfb_pkg::*;

    localparam int CW = $clog2(SCREEN_WIDTH + 1);
    localparam int RW = $clog2(SCREEN_HEIGHT + 1);
    localparam int XB = CW - 3;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GEN  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_WR   = 4'd3;
    localparam logic [3:0] S_CLR  = 4'd4;
    localparam logic [3:0] S_RB   = 4'd5;
    localparam logic [3:0] S_RB2  = 4'd6;
    localparam logic [3:0] S_DONE = 4'd7;

    logic [3:0]    state_reg, state_next;
    cmd_t          cmd_reg, cmd_next;
    logic [5:0]    pidx_reg, pidx_next;
    logic [CW-1:0] x0_reg, x0_next, x1_reg, x1_next;
    logic [RW-1:0] y_reg, y_next, y1_reg, y1_next;
    logic [XB-1:0] bcol_reg, bcol_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [7:0]    rd_reg, rd_next;

    logic [3:0]    sc_eff;
    logic [6:0]    ofs_x, ofs_y;
    coord_t        xs, ys, xe, ye, ln, px, py, sc_c;
    coord_t        bx0, by0, bx1, by1;
    coord_t        cx0, cy0, cx1, cy1;
    logic          bon, box_ok, last_part;
    logic [31:0]   base_calc;
    logic [7:0]    mask;
    logic [CW-1:0] x1m1;
    logic          row_end, box_end;
    logic [31:0]   bidx_w;
    logic [AW-1:0] addr;
    logic [7:0]    fill_byte;
    logic signed [17:0] pen;

    assign xs     = coord_t'(cmd_reg.x_start);
    assign ys     = coord_t'(cmd_reg.y_start);
    assign xe     = coord_t'(cmd_reg.x_end);
    assign ye     = coord_t'(cmd_reg.y_end);
    assign ln     = coord_t'(cmd_reg.length);
    assign sc_eff = (cmd_reg.scale == 4'd0) ? 4'd1 : cmd_reg.scale;
    assign sc_c   = coord_t'({16'd0, sc_eff});
    assign ofs_x  = 7'(pidx_reg[2:0]) * 7'(sc_eff);
    assign ofs_y  = 7'(pidx_reg[5:3]) * 7'(sc_eff);
    assign px     = xs + coord_t'({13'd0, ofs_x});
    assign py     = ys + coord_t'({13'd0, ofs_y});

    always_comb
    begin
        bon       = 1'b1;
        bx0       = xs;
        by0       = ys;
        bx1       = xe;
        by1       = ye;
        last_part = 1'b1;
        case (cmd_reg.action)
            ACT_PIXEL:
            begin
                bx1 = xs + coord_t'(1);
                by1 = ys + coord_t'(1);
            end
            ACT_OUTLINE:
            begin
                last_part = (pidx_reg[1:0] == 2'd3);
                case (pidx_reg[1:0])
                    2'd0:    by1 = ys + coord_t'(1);
                    2'd1:    by0 = ye - coord_t'(1);
                    2'd2:    bx1 = xs + coord_t'(1);
                    default: bx0 = xe - coord_t'(1);
                endcase
            end
            ACT_HLINE:
            begin
                bx1 = xs + ln;
                by1 = ys + coord_t'(1);
            end
            ACT_VLINE:
            begin
                bx1 = xs + coord_t'(1);
                by1 = ys + ln;
            end
            ACT_GLYPH:
            begin
                last_part = (pidx_reg == 6'd63);
                bon       = cmd_reg.glyph_bits[~pidx_reg];
                bx0       = px;
                by0       = py;
                bx1       = px + sc_c;
                by1       = py + sc_c;
            end
            default:
            begin
                bon = 1'b1;
            end
        endcase
    end

    assign cx0    = (bx0 < 0) ? coord_t'(0) : bx0;
    assign cy0    = (by0 < 0) ? coord_t'(0) : by0;
    assign cx1    = (bx1 > coord_t'(SCREEN_WIDTH)) ? coord_t'(SCREEN_WIDTH) : bx1;
    assign cy1    = (by1 > coord_t'(SCREEN_HEIGHT)) ? coord_t'(SCREEN_HEIGHT) : by1;
    assign box_ok = bon && (cx0 < cx1) && (cy0 < cy1);
    assign base_calc = 32'(cy0[RW-1:0]) * 32'(ROW_BYTES);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            mask[7 - i] = ({bcol_reg, 3'(i)} >= x0_reg) && ({bcol_reg, 3'(i)} < x1_reg);
        end
    end

    assign x1m1      = x1_reg - CW'(1);
    assign row_end   = (bcol_reg == x1m1[CW-1:3]);
    assign box_end   = row_end && ((y_reg + RW'(1)) == y1_reg);
    assign addr      = base_reg + AW'(bcol_reg);
    assign fill_byte = cmd_reg.color ? 8'hFF : 8'h00;
    assign bidx_w    = {20'd0, cmd_reg.byte_index};

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pidx_next  = pidx_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        y_next     = y_reg;
        y1_next    = y1_reg;
        bcol_next  = bcol_reg;
        base_next  = base_reg;
        clr_next   = clr_reg;
        rd_next    = rd_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr;
        ram_wdata  = fill_byte;
        ram_re     = 1'b0;
        ram_raddr  = addr;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd;
                    pidx_next = 6'd0;
                    clr_next  = '0;
                    rd_next   = 8'h00;
                    case (cmd.action)
                        ACT_CLEAR: state_next = S_CLR;
                        ACT_READ:  state_next = S_RB;
                        default:   state_next = S_GEN;
                    endcase
                end
            end
            S_GEN:
            begin
                if (box_ok)
                begin
                    x0_next    = cx0[CW-1:0];
                    x1_next    = cx1[CW-1:0];
                    y_next     = cy0[RW-1:0];
                    y1_next    = cy1[RW-1:0];
                    bcol_next  = cx0[CW-1:3];
                    base_next  = base_calc[AW-1:0];
                    state_next = S_RD;
                end
                else if (last_part)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pidx_next = pidx_reg + 6'd1;
                end
            end
            S_RD, S_WR:
            begin
                if (state_reg == S_RD && mask != 8'hFF)
                begin
                    ram_re     = 1'b1;
                    state_next = S_WR;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (state_reg == S_WR)
                    begin
                        ram_wdata = (ram_rdata & ~mask) | (fill_byte & mask);
                    end
                    state_next = S_RD;
                    if (box_end)
                    begin
                        if (last_part)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            pidx_next  = pidx_reg + 6'd1;
                            state_next = S_GEN;
                        end
                    end
                    else if (row_end)
                    begin
                        y_next    = y_reg + RW'(1);
                        base_next = base_reg + AW'(ROW_BYTES);
                        bcol_next = x0_reg[CW-1:3];
                    end
                    else
                    begin
                        bcol_next = bcol_reg + XB'(1);
                    end
                end
            end
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            S_RB:
            begin
                ram_re     = 1'b1;
                ram_raddr  = bidx_w[AW-1:0];
                state_next = S_RB2;
            end
            S_RB2:
            begin
                rd_next    = (bidx_w < 32'(STORE_BYTES)) ? ram_rdata : 8'h00;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign pen = 18'(cmd_reg.x_start) + $signed({11'd0, sc_eff, 3'd0});

    always_comb
    begin
        res.read_data = rd_reg;
        res.next_x    = 16'sd0;
        if (cmd_reg.action == ACT_GLYPH)
        begin
            res.next_x = (pen > 18'sd32767) ? 16'sd32767 : pen[15:0];
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pidx_reg <= pidx_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        y_reg    <= y_next;
        y1_reg   <= y1_next;
        bcol_reg <= bcol_next;
        base_reg <= base_next;
        clr_reg  <= clr_next;
        rd_reg   <= rd_next;
    end

endmodule

### src/mono_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// operation: a word is latched into the sequencer, then per command: clear writes every byte of the
// store, read fetches one byte, shapes scan each part in turn (1 rect, 4 outline, 64 glyph) and write
// each touched byte whole, or by read-modify-write on the frame memory for a partial byte; the result
// is then handed to the output register
// throughput: one command at a time; the next word is taken once the result is registered
// reset: control and output valid clear asynchronously; the frame memory is not cleared
module mono_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = mfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = mfb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         action,
    input  logic signed [15:0] x_start,
    input  logic signed [15:0] y_start,
    input  logic signed [15:0] x_end,
    input  logic signed [15:0] y_end,
    input  logic signed [15:0] length,
    input  logic               color,
    input  logic [63:0]        glyph_bits,
    input  logic [3:0]         scale,
    input  logic [11:0]        byte_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_data,
    output logic signed [15:0] next_x
);

    import mfb_pkg::*;

    localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    cmd_t          cmd;
    result_t       res;
    logic          busy, done, res_take;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          out_valid_reg;
    result_t       res_reg;

    assign cmd.action     = action;
    assign cmd.x_start    = x_start;
    assign cmd.y_start    = y_start;
    assign cmd.x_end      = x_end;
    assign cmd.y_end      = y_end;
    assign cmd.length     = length;
    assign cmd.color      = color;
    assign cmd.glyph_bits = glyph_bits;
    assign cmd.scale      = scale;
    assign cmd.byte_index = byte_index;

    assign in_ready = !busy;
    assign res_take = !out_valid_reg || out_ready;

    mfb_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && in_ready),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .res       (res),
        .res_take  (res_take),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    mfb_ram #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && res_take)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = res_reg.read_data;
    assign next_x    = res_reg.next_x;

endmodule

### src/mfb_checker.sv
`timescale 1ns / 1ps
`include "mono_framebuffer_draw_engine_assert.svh"
module mfb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  read_data,
    input logic [15:0] next_x
);

    `MFB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `MFB_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(read_data) && $stable(next_x))
    `MFB_ASSERT_NEXT(a_busy_after_word, clk, rst_n, in_valid && in_ready, ##1 !in_ready)
    `MFB_ASSERT_NOW(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind mono_framebuffer_draw_engine mfb_checker u_mfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .next_x    (next_x)
);

### dv/draw_engine_checker.sv
`timescale 1ns / 1ps
module draw_engine_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         action,
    input  logic signed [15:0] x_start,
    input  logic signed [15:0] y_start,
    input  logic signed [15:0] x_end,
    input  logic signed [15:0] y_end,
    input  logic signed [15:0] length,
    input  logic               color,
    input  logic [63:0]        glyph_bits,
    input  logic [3:0]         scale,
    input  logic [11:0]        byte_index,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [7:0]         read_data,
    input  logic signed [15:0] next_x,
    output int                 errors,
    output int                 pending
);

    import mfb_pkg::*;

    localparam int ROW_BYTES   = (SCREEN_WIDTH_DEF + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT_DEF;

    logic [7:0] frame_model [STORE_BYTES];
    result_t    expected_q [$];

    task automatic plot(input int x, input int y, input logic white);
        int idx;
        begin
            if (x < 0 || x >= SCREEN_WIDTH_DEF || y < 0 || y >= SCREEN_HEIGHT_DEF)
                return;
            idx = y * ROW_BYTES + (x >> 3);
            frame_model[idx][7 - (x & 7)] = white;
        end
    endtask

    task automatic paint_box(input int x0, input int y0, input int x1, input int y1,
                             input logic white);
        begin
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > SCREEN_WIDTH_DEF) x1 = SCREEN_WIDTH_DEF;
            if (y1 > SCREEN_HEIGHT_DEF) y1 = SCREEN_HEIGHT_DEF;
            for (int y = y0; y < y1; y++)
                for (int x = x0; x < x1; x++)
                    plot(x, y, white);
        end
    endtask

    task automatic hspan(input int x, input int y, input int len, input logic white);
        begin
            if (len > 0) paint_box(x, y, x + len, y + 1, white);
        end
    endtask

    task automatic vspan(input int x, input int y, input int len, input logic white);
        begin
            if (len > 0) paint_box(x, y, x + 1, y + len, white);
        end
    endtask

    task automatic draw_command(output result_t res);
        int xs, ys, xe, ye, sc, pen, px, py;
        begin
            xs = x_start;
            ys = y_start;
            xe = x_end;
            ye = y_end;
            res = '0;
            case (action)
                ACT_CLEAR:
                    for (int i = 0; i < STORE_BYTES; i++)
                        frame_model[i] = color ? 8'hFF : 8'h00;
                ACT_PIXEL:   plot(xs, ys, color);
                ACT_FILL:    paint_box(xs, ys, xe, ye, color);
                ACT_OUTLINE:
                begin
                    hspan(xs, ys, xe - xs, color);
                    hspan(xs, ye - 1, xe - xs, color);
                    vspan(xs, ys, ye - ys, color);
                    vspan(xe - 1, ys, ye - ys, color);
                end
                ACT_HLINE:   hspan(xs, ys, length, color);
                ACT_VLINE:   vspan(xs, ys, length, color);
                ACT_GLYPH:
                begin
                    sc = (scale == 0) ? 1 : scale;
                    for (int r = 0; r < 8; r++)
                        for (int c = 0; c < 8; c++)
                            if (glyph_bits[63 - (r * 8 + c)])
                            begin
                                px = xs + c * sc;
                                py = ys + r * sc;
                                paint_box(px, py, px + sc, py + sc, color);
                            end
                    pen = xs + 8 * sc;
                    if (pen > 32767) pen = 32767;
                    res.next_x = pen[15:0];
                end
                default:
                    if (byte_index < STORE_BYTES) res.read_data = frame_model[byte_index];
            endcase
        end
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word read_data=%h next_x=%0d",
                             $time, read_data, next_x);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (read_data !== want.read_data)
                    begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, read_data);
                        errors++;
                    end
                    if (next_x !== want.next_x)
                    begin
                        $display("%0t: next_x expected %0d actual %0d",
                                 $time, want.next_x, next_x);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                draw_command(got);
                expected_q.push_back(got);
            end
            pending = expected_q.size();
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import mfb_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         action;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic signed [15:0] length;
    logic               color;
    logic [63:0]        glyph_bits;
    logic [3:0]         scale;
    logic [11:0]        byte_index;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         read_data;
    logic signed [15:0] next_x;
    int                 errors;
    int                 pending;
    bit                 burst;

    mono_framebuffer_draw_engine DUT (.*);

    draw_engine_checker checker_i (.*);

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_word(input logic [2:0] act, input int xs, input int ys,
                             input int xe, input int ye, input int len,
                             input logic col, input logic [63:0] gl,
                             input logic [3:0] sc, input logic [11:0] bi);
        int  gap;
        bit  rdy;
        begin
            gap = burst ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                @(negedge clk) in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            in_valid   <= 1'b1;
            action     <= act;
            x_start    <= xs[15:0];
            y_start    <= ys[15:0];
            x_end      <= xe[15:0];
            y_end      <= ye[15:0];
            length     <= len[15:0];
            color      <= col;
            glyph_bits <= gl;
            scale      <= sc;
            byte_index <= bi;
            forever
            begin
                #1 rdy = in_ready;
                @(posedge clk);
                if (rdy) break;
                @(negedge clk);
            end
        end
    endtask

    function automatic int pick_coord(input int span);
        begin
            case ($urandom_range(0, 9))
                0: return $signed(16'($urandom));
                1: return 32767 - $urandom_range(0, 20);
                default: return $urandom_range(0, span + 40) - 20;
            endcase
        end
    endfunction

    task automatic random_word();
        logic [2:0] act;
        int         xs, ys, xe, ye, len, pick;
        logic [3:0] sc;
        begin
            pick = $urandom_range(0, 99);
            if (pick == 0) act = ACT_CLEAR;
            else act = 3'($urandom_range(1, 7));
            xs = pick_coord(SCREEN_WIDTH_DEF);
            ys = pick_coord(SCREEN_HEIGHT_DEF);
            if ($urandom_range(0, 7) == 0)
            begin
                xe = pick_coord(SCREEN_WIDTH_DEF);
                ye = pick_coord(SCREEN_HEIGHT_DEF);
            end
            else
            begin
                xe = xs + $urandom_range(0, 40) - 4;
                ye = ys + $urandom_range(0, 24) - 4;
            end
            len = ($urandom_range(0, 7) == 0) ? $signed(16'($urandom))
                                              : $urandom_range(0, 60) - 5;
            sc = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
            send_word(act, xs, ys, xe, ye, len, 1'($urandom), {$urandom, $urandom}, sc,
                      12'($urandom));
        end
    endtask

    initial
    begin
        int   n;
        bit   seen;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = (burst || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            repeat (n) @(negedge clk) out_ready <= 1'b0;
            @(negedge clk) out_ready <= 1'b1;
            forever
            begin
                #1 seen = out_valid;
                @(posedge clk);
                if (seen) break;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_CLEAR;
        x_start    = '0;
        y_start    = '0;
        x_end      = '0;
        y_end      = '0;
        length     = '0;
        color      = 1'b0;
        glyph_bits = '0;
        scale      = '0;
        byte_index = '0;
        burst      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // store is undefined until the first clear
        send_word(ACT_CLEAR, 0, 0, 0, 0, 0, 1'b1, '0, 4'd0, 12'd0);
        send_word(ACT_READ, 0, 0, 0, 0, 0, 1'b0, '0, 4'd0, 12'd0);
        send_word(ACT_CLEAR, 0, 0, 0, 0, 0, 1'b0, '0, 4'd0, 12'd0);
        send_word(ACT_PIXEL, 0, 0, 0, 0, 0, 1'b1, '0, 4'd0, 12'd0);
        send_word(ACT_PIXEL, 255, 127, 0, 0, 0, 1'b1, '0, 4'd0, 12'd0);
        send_word(ACT_PIXEL, -1, 256, 0, 0, 0, 1'b1, '0, 4'd0, 12'd0);
        send_word(ACT_PIXEL, -32768, 32767, 0, 0, 0, 1'b1, '0, 4'd0, 12'd0);
        send_word(ACT_READ, 0, 0, 0, 0, 0, 1'b0, '0, 4'd0, 12'd4095);
        send_word(ACT_FILL, 3, 5, 3, 20, 0, 1'b1, '0, 4'd0, 12'd0);
        send_word(ACT_FILL, 10, 10, 5, 5, 0, 1'b1, '0, 4'd0, 12'd0);
        send_word(ACT_FILL, -32768, -32768, 32767, 32767, 0, 1'b1, '0, 4'd0, 12'd0);
        send_word(ACT_FILL, 7, 3, 61, 19, 0, 1'b0, '0, 4'd0, 12'd0);
        send_word(ACT_OUTLINE, 2, 2, 90, 40, 0, 1'b1, '0, 4'd0, 12'd0);
        send_word(ACT_OUTLINE, -10, 120, 300, 140, 0, 1'b0, '0, 4'd0, 12'd0);
        send_word(ACT_HLINE, 250, 64, 0, 0, 20, 1'b0, '0, 4'd0, 12'd0);
        send_word(ACT_HLINE, 5, 5, 0, 0, 0, 1'b0, '0, 4'd0, 12'd0);
        send_word(ACT_HLINE, 5, 5, 0, 0, -32768, 1'b0, '0, 4'd0, 12'd0);
        send_word(ACT_VLINE, 100, -5, 0, 0, 32767, 1'b0, '0, 4'd0, 12'd0);
        send_word(ACT_GLYPH, 30, 30, 0, 0, 0, 1'b0, 64'h8142_2418_1824_4281, 4'd0, 12'd0);
        send_word(ACT_GLYPH, 200, 100, 0, 0, 0, 1'b1, '1, 4'd15, 12'd0);
        send_word(ACT_GLYPH, 32767, 0, 0, 0, 0, 1'b1, '1, 4'd15, 12'd0);
        send_word(ACT_GLYPH, -32768, -32768, 0, 0, 0, 1'b1, '0, 4'd1, 12'd0);
        send_word(ACT_READ, 0, 0, 0, 0, 0, 1'b0, '0, 4'd0, 12'd2048);

        for (int i = 0; i < 750; i++)
        begin
            if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
            if (i == 300)
            begin
                @(negedge clk) in_valid <= 1'b0;
                wait_cycles = 0;
                while (pending != 0 && wait_cycles < 200_000)
                begin
                    @(negedge clk);
                    wait_cycles++;
                end
            end
            random_word();
        end
        @(negedge clk) in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 2_000_000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (100) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### mono_framebuffer_draw_engine.f
+incdir+src
src/mfb_pkg.sv
src/mfb_ram.sv
src/mfb_seq.sv
src/mono_framebuffer_draw_engine.sv
src/mfb_checker.sv
dv/draw_engine_checker.sv
dv/testbench.sv
